[sv/wor_pkg.sv]
// Shared types, constants and the legacy opcode map for the opcode rewriter.
// Used by wor_front, wor_queue, wor_back and the top level; no dependencies.
package wor_pkg;

  localparam int WIN_DEPTH = 7;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = QAW + 1;

  localparam logic [7:0] OP_DROP     = 8'h1a;
  localparam logic [7:0] OP_I32CONST = 8'h41;
  localparam logic [7:0] OP_I64CONST = 8'h42;
  localparam logic [7:0] OP_F32CONST = 8'h43;
  localparam logic [7:0] OP_F64CONST = 8'h44;
  localparam logic [7:0] OP_CALL     = 8'h10;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;

  typedef enum logic [1:0] {
    LEN_NONE,
    LEN_ONE,
    LEN_THREE
  } len_t;

  typedef struct packed {
    len_t       len;
    logic [7:0] b0;
    logic [7:0] b1;
  } legacy_map_t;

  // One queued run of output bytes: one byte, or three (b0, b1, zero).
  typedef struct packed {
    logic       triple;
    logic [7:0] b0;
    logic [7:0] b1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_marker(input logic [7:0] b);
    return (b == OP_I32CONST) || (b == OP_I64CONST) || (b == OP_F32CONST) ||
           (b == OP_F64CONST) || (b == OP_CALL);
  endfunction

  function automatic legacy_map_t legacy_map(input logic [7:0] b);
    legacy_map_t m;
    m = '{len: LEN_NONE, b0: BYTE_ZERO, b1: BYTE_ZERO};
    unique case (b) inside
      [8'hc5:8'hcc]: m = '{len: LEN_ONE, b0: 8'h9f, b1: BYTE_ZERO};
      [8'hcd:8'hcf]: m = '{len: LEN_ONE, b0: 8'ha3, b1: BYTE_ZERO};
      8'hd3: m = '{len: LEN_ONE, b0: 8'h6d, b1: BYTE_ZERO};
      8'hd4: m = '{len: LEN_ONE, b0: 8'h6e, b1: BYTE_ZERO};
      8'hd5: m = '{len: LEN_ONE, b0: 8'h6f, b1: BYTE_ZERO};
      8'hd6: m = '{len: LEN_ONE, b0: 8'h70, b1: BYTE_ZERO};
      8'hd7: m = '{len: LEN_THREE, b0: 8'h2c, b1: 8'h00};
      8'hd8: m = '{len: LEN_THREE, b0: 8'h2d, b1: 8'h00};
      8'hd9: m = '{len: LEN_THREE, b0: 8'h2e, b1: 8'h01};
      8'hda: m = '{len: LEN_THREE, b0: 8'h2f, b1: 8'h01};
      8'hdb: m = '{len: LEN_THREE, b0: 8'h28, b1: 8'h02};
      8'hdc: m = '{len: LEN_THREE, b0: 8'h2a, b1: 8'h02};
      8'hdd: m = '{len: LEN_THREE, b0: 8'h2b, b1: 8'h04};
      8'hde: m = '{len: LEN_THREE, b0: 8'h3a, b1: 8'h00};
      8'hdf: m = '{len: LEN_THREE, b0: 8'h3b, b1: 8'h01};
      8'he0: m = '{len: LEN_THREE, b0: 8'h36, b1: 8'h02};
      8'he1: m = '{len: LEN_THREE, b0: 8'h38, b1: 8'h02};
      8'he2: m = '{len: LEN_THREE, b0: 8'h39, b1: 8'h04};
      8'he3: m = '{len: LEN_ONE, b0: 8'ha8, b1: BYTE_ZERO};
      8'he4: m = '{len: LEN_ONE, b0: 8'ha9, b1: BYTE_ZERO};
      8'he5: m = '{len: LEN_ONE, b0: 8'haa, b1: BYTE_ZERO};
      8'he6: m = '{len: LEN_ONE, b0: 8'hab, b1: BYTE_ZERO};
      default: m = '{len: LEN_NONE, b0: BYTE_ZERO, b1: BYTE_ZERO};
    endcase
    return m;
  endfunction

endpackage

[sv/wor_queue.sv]
// Small show-ahead FIFO of classified entries between front and back.
// Depends on wor_pkg for the entry type and depth constants.
module wor_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wor_pkg::entry_t    push_data,
  input  logic               pop,
  output wor_pkg::entry_t    head,
  output wor_pkg::q_status_t status
);

  wor_pkg::entry_t mem [0:wor_pkg::QDEPTH-1];
  logic [wor_pkg::QAW-1:0] wr_ptr;
  logic [wor_pkg::QAW-1:0] rd_ptr;
  logic [wor_pkg::QCW-1:0] count;

  logic do_push;
  logic do_pop;

  assign status.full  = (count == wor_pkg::QCW'(wor_pkg::QDEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/wor_front.sv]
// Front end: accepts input items, keeps the look-back window and the store
// flag, classifies each byte and pushes its output run. Depends on wor_pkg.
module wor_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_body,
  input  logic               body_start,
  input  wor_pkg::q_status_t q_status,
  output logic               push,
  output wor_pkg::entry_t    push_data
);

  logic [7:0] window [0:wor_pkg::WIN_DEPTH-1];
  logic       after_store;

  logic                 accept;
  logic                 flag_eff;
  logic                 leb;
  logic                 after_store_next;
  wor_pkg::legacy_map_t map;

  // Look back over the window to guess whether this byte sits inside a LEB.
  function automatic logic looks_like_leb(input logic [7:0] w [0:wor_pkg::WIN_DEPTH-1]);
    logic res;
    logic done;
    logic found;
    res   = 1'b1;
    done  = 1'b0;
    found = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!done && !w[k][7]) begin
        done = 1'b1;
        if (!wor_pkg::is_marker(w[k])) begin
          res = 1'b0;
        end else begin
          res = 1'b1;
          for (int n = 1; n <= 3; n++) begin
            if (!found && !w[k+n][7]) begin
              found = 1'b1;
              res   = !wor_pkg::is_marker(w[k+n]);
            end
          end
        end
      end
    end
    return res;
  endfunction

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign flag_eff = after_store && !body_start;
  assign map      = wor_pkg::legacy_map(in_byte);
  assign leb      = looks_like_leb(window);

  always_comb begin
    push             = 1'b0;
    push_data        = '{triple: 1'b0, b0: in_byte, b1: wor_pkg::BYTE_ZERO};
    after_store_next = 1'b0;
    if (!in_body) begin
      push = accept;
    end else if (in_byte == wor_pkg::OP_DROP && flag_eff) begin
      push = 1'b0;
    end else if (map.len != wor_pkg::LEN_NONE && !leb) begin
      push = accept;
      push_data.b0 = map.b0;
      if (map.len == wor_pkg::LEN_THREE) begin
        push_data.triple = 1'b1;
        push_data.b1     = map.b1;
        after_store_next = 1'b1;
      end
    end else begin
      push = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      after_store <= 1'b0;
      for (int i = 0; i < wor_pkg::WIN_DEPTH; i++) begin
        window[i] <= '0;
      end
    end else if (accept) begin
      after_store <= after_store_next;
      window[0]   <= in_byte;
      for (int i = 1; i < wor_pkg::WIN_DEPTH; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

endmodule

[sv/wor_back.sv]
// Back end: walks each queued run, one byte per cycle unless stalled, into the
// output register. Depends on wor_pkg for the entry and queue status types.
module wor_back (
  input  logic               clk,
  input  logic               rst,
  input  wor_pkg::q_status_t q_status,
  input  wor_pkg::entry_t    head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               last_of_run
);

  typedef enum logic [1:0] {
    POS_FIRST,
    POS_MID,
    POS_LAST
  } pos_t;

  pos_t       pos;
  pos_t       pos_next;
  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = (!out_valid || out_ready) && !q_status.empty;
  assign is_last = !head.triple || (pos == POS_LAST);
  assign pop     = load && is_last;

  always_comb begin
    sel_byte = wor_pkg::BYTE_ZERO;
    pos_next = POS_FIRST;
    unique case (pos)
      POS_FIRST: begin
        sel_byte = head.b0;
        pos_next = POS_MID;
      end
      POS_MID: begin
        sel_byte = head.b1;
        pos_next = POS_LAST;
      end
      POS_LAST: begin
        sel_byte = wor_pkg::BYTE_ZERO;
        pos_next = POS_FIRST;
      end
      default: begin
        sel_byte = wor_pkg::BYTE_ZERO;
        pos_next = POS_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      out_byte    <= wor_pkg::BYTE_ZERO;
      last_of_run <= 1'b0;
      pos         <= POS_FIRST;
    end else begin
      if (load) begin
        out_valid   <= 1'b1;
        out_byte    <= sel_byte;
        last_of_run <= is_last;
        pos         <= is_last ? POS_FIRST : pos_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/wasm_opcode_rewriter.sv]
// Top level of the legacy opcode rewriter: front classifier, run queue, back end.
// Depends on wor_pkg, wor_front, wor_queue and wor_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one module byte per item, with in_body
//   marking function-body bytes and body_start the first byte of each body.
//   Output channel (out_valid/out_ready): one byte per item; last_of_run is
//   high on the final byte caused by an input item. A body 0x1a right after a
//   three-byte store expansion causes no output at all.
// Path: an accepted item is written into the run queue; its first output byte
//   is then loaded from the queue head into the output register.
// Throughput: one input item per cycle while the output side takes one byte
//   per cycle; a store expansion emits three output bytes, so the output
//   port's one byte per cycle sets the pace on expanded runs. The front keeps
//   accepting until the four-entry run queue fills.
// Reset: clears the look-back window to zero bytes, the store flag, the queue
//   and the output register; no item is in flight afterwards.
// Stall: when out_ready is low the output byte holds, the queue absorbs up to
//   four runs behind it, then in_ready drops until the back end drains an entry.
module wasm_opcode_rewriter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_body,
  input  logic       body_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  wor_pkg::q_status_t q_status;
  wor_pkg::entry_t    push_data;
  wor_pkg::entry_t    head;
  logic               push;
  logic               pop;

  // Classify bytes, track the window and the store flag.
  wor_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_body    (in_body),
    .body_start (body_start),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data)
  );

  // Decouple classification from byte emission.
  wor_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // Emit each run through the output register, one byte per cycle unless stalled.
  wor_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

[sv/wor_checker.sv]
// Port-level checker for wasm_opcode_rewriter, attached through bind.
// Depends only on the top level's ports.
module wor_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  logic       out_acc;
  logic [1:0] run_cnt;

  assign out_acc = out_valid && out_ready;

  // Count bytes of the current run handed over so far.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
    end else if (out_acc) begin
      run_cnt <= last_of_run ? 2'd0 : run_cnt + 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("stalled output byte changed");

  a_mid_not_last: assert property (@(posedge clk) disable iff (rst)
    out_acc && run_cnt == 2'd1 |-> !last_of_run)
    else $error("expanded run ended after two bytes");

  a_third_zero: assert property (@(posedge clk) disable iff (rst)
    out_acc && run_cnt == 2'd2 |-> last_of_run && out_byte == 8'h00)
    else $error("third byte of expanded run is not a final zero");

endmodule

bind wasm_opcode_rewriter wor_checker u_wor_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .last_of_run (last_of_run)
);

[tb/tb_wasm_opcode_rewriter.sv]
// Self-checking bench for wasm_opcode_rewriter: random and directed module bytes,
// each output byte checked against an in-bench model of the rewrite rules.
// Depends on wor_pkg and the wasm_opcode_rewriter RTL.
module tb_wasm_opcode_rewriter;

  // Generous cycle budget: about 450 items, up to three bytes each, a receiver
  // that idles up to 60% of the time, and a couple of long hold-offs.
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;
  localparam logic [7:0] LEGACY_FIRST = 8'hc5;
  localparam logic [7:0] LEGACY_LAST  = 8'he6;
  localparam logic [7:0] STORE_FIRST  = 8'hd7;
  localparam logic [7:0] STORE_LAST   = 8'he2;

  // Model of the rewriter: own copy of the look-back window and store flag,
  // and the queue of output bytes still owed by the block.
  class rewrite_scoreboard;
    typedef struct packed {
      logic [7:0] value;
      logic       last;
    } out_byte_t;

    out_byte_t  owed_q[$];
    logic [7:0] recent[wor_pkg::WIN_DEPTH];
    bit         store_pending;
    int         errors;
    int         n_in;
    int         n_out;
    int         n_dropped;
    int         n_stores;
    int         n_leb_kept;

    function void clear();
      foreach (recent[i]) recent[i] = 8'h00;
      store_pending = 0;
      owed_q.delete();
    endfunction

    // Append one owed byte at the tail of the queue.
    function void owe(input logic [7:0] b, input logic fin);
      out_byte_t item;
      item.value = b;
      item.last  = fin;
      owed_q.insert(owed_q.size(), item);
    endfunction

    function bit const_or_call(input logic [7:0] b);
      return b == wor_pkg::OP_I32CONST || b == wor_pkg::OP_I64CONST ||
             b == wor_pkg::OP_F32CONST || b == wor_pkg::OP_F64CONST ||
             b == wor_pkg::OP_CALL;
    endfunction

    // Scan back for the first byte with bit 7 clear; an operand of a
    // const or call means the candidate sits inside an LEB immediate.
    function bit inside_leb();
      for (int k = 0; k < 4; k++) begin
        if (!recent[k][7]) begin
          if (!const_or_call(recent[k])) return 0;
          for (int n = 1; n <= 3; n++) begin
            if (!recent[k + n][7]) return !const_or_call(recent[k + n]);
          end
          return 1;
        end
      end
      return 1;
    endfunction

    function void rewrite(input logic [7:0] b, output wor_pkg::len_t len,
                          output logic [7:0] b0, output logic [7:0] b1);
      len = wor_pkg::LEN_ONE;
      b1  = wor_pkg::BYTE_ZERO;
      b0  = b;
      if (b >= 8'hc5 && b <= 8'hcc) b0 = 8'h9f;
      else if (b >= 8'hcd && b <= 8'hcf) b0 = 8'ha3;
      else if (b >= 8'hd3 && b <= 8'hd6) b0 = b - 8'hd3 + 8'h6d;
      else if (b >= 8'he3 && b <= 8'he6) b0 = b - 8'he3 + 8'ha8;
      else if (b >= STORE_FIRST && b <= STORE_LAST) begin
        len = wor_pkg::LEN_THREE;
        case (b)
          8'hd7: begin b0 = 8'h2c; b1 = 8'h00; end
          8'hd8: begin b0 = 8'h2d; b1 = 8'h00; end
          8'hd9: begin b0 = 8'h2e; b1 = 8'h01; end
          8'hda: begin b0 = 8'h2f; b1 = 8'h01; end
          8'hdb: begin b0 = 8'h28; b1 = 8'h02; end
          8'hdc: begin b0 = 8'h2a; b1 = 8'h02; end
          8'hdd: begin b0 = 8'h2b; b1 = 8'h04; end
          8'hde: begin b0 = 8'h3a; b1 = 8'h00; end
          8'hdf: begin b0 = 8'h3b; b1 = 8'h01; end
          8'he0: begin b0 = 8'h36; b1 = 8'h02; end
          8'he1: begin b0 = 8'h38; b1 = 8'h02; end
          default: begin b0 = 8'h39; b1 = 8'h04; end
        endcase
      end else len = wor_pkg::LEN_NONE;
    endfunction

    function void note_input(input logic [7:0] b, input logic body, input logic start);
      wor_pkg::len_t len;
      logic [7:0]    b0;
      logic [7:0]    b1;
      n_in++;
      if (start) store_pending = 0;
      rewrite(b, len, b0, b1);
      if (!body) begin
        owe(b, 1'b1);
        store_pending = 0;
      end else if (b == wor_pkg::OP_DROP && store_pending) begin
        store_pending = 0;
        n_dropped++;
      end else if (len != wor_pkg::LEN_NONE && !inside_leb()) begin
        if (len == wor_pkg::LEN_THREE) begin
          owe(b0, 1'b0);
          owe(b1, 1'b0);
          owe(wor_pkg::BYTE_ZERO, 1'b1);
          store_pending = 1;
          n_stores++;
        end else begin
          owe(b0, 1'b1);
          store_pending = 0;
        end
      end else begin
        if (len != wor_pkg::LEN_NONE) n_leb_kept++;
        owe(b, 1'b1);
        store_pending = 0;
      end
      for (int i = wor_pkg::WIN_DEPTH - 1; i > 0; i--) recent[i] = recent[i - 1];
      recent[0] = b;
    endfunction

    function void check_output(input logic [7:0] value, input logic last);
      out_byte_t want;
      n_out++;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected output, expected no byte, actual %02h last %0b",
                 $time, value, last);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (value !== want.value) begin
        $display("%0t: out_byte mismatch, expected %02h actual %02h",
                 $time, want.value, value);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_of_run mismatch, expected %0b actual %0b",
                 $time, want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_body;
  logic       body_start;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  rewrite_scoreboard sb = new;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  bit hold_request = 0;
  int hold_left    = 0;
  int cycle_count  = 0;

  wasm_opcode_rewriter dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_body    (in_body),
    .body_start (body_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: end the run if the drain never completes.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d bytes still owed", cycle_count, sb.pending());
    $display("tb: failure");
    $finish;
  end

  // Sample both handshakes at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_byte, in_body, body_start);
      if (out_valid && out_ready) sb.check_output(out_byte, last_of_run);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request so the run queue
  // fills and in_ready drops while the sender keeps offering items.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Offer one item, idling first at the current rate; return at the falling
  // edge after the item is taken, with valid still high.
  task automatic send_byte(input logic [7:0] b, input logic body, input logic start);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_byte    = b;
    in_body    = body;
    body_start = start;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_marker();
    case ($urandom_range(4))
      0: send_byte(wor_pkg::OP_I32CONST, 1'b1, 1'b0);
      1: send_byte(wor_pkg::OP_I64CONST, 1'b1, 1'b0);
      2: send_byte(wor_pkg::OP_F32CONST, 1'b1, 1'b0);
      3: send_byte(wor_pkg::OP_F64CONST, 1'b1, 1'b0);
      default: send_byte(wor_pkg::OP_CALL, 1'b1, 1'b0);
    endcase
  endtask

  // Random module text: bodies of random length opened by body_start, with
  // header bytes between them. Body content leans on legacy opcodes, const and
  // call operands, LEB continuation bytes and drops after stores.
  task automatic feed_stream(input int count);
    int         body_left;
    int         pick;
    bit         first;
    bit         after_store;
    logic [7:0] b;
    body_left   = 0;
    first       = 0;
    after_store = 0;
    for (int i = 0; i < count; i++) begin
      if (body_left == 0) begin
        repeat ($urandom_range(2))
          send_byte(8'($urandom_range(255)), 1'b0, $urandom_range(99) < 5);
        body_left   = $urandom_range(24, 1);
        first       = 1;
        after_store = 0;
      end
      pick = $urandom_range(99);
      if (!first && pick < 15) begin
        // Operand first: a const or call followed by what the rest of the
        // body brings, so the look-back sees real-looking immediates.
        send_marker();
        after_store = 0;
      end else begin
        if (after_store && pick < 60) b = wor_pkg::OP_DROP;
        else if (pick < 50) b = 8'($urandom_range(LEGACY_LAST, LEGACY_FIRST));
        else if (pick < 65) b = 8'h80 | 8'($urandom_range(127));
        else if (pick < 72) b = wor_pkg::OP_DROP;
        else b = 8'($urandom_range(255));
        send_byte(b, 1'b1, first || ($urandom_range(99) < 3));
        after_store = (b >= STORE_FIRST && b <= STORE_LAST);
      end
      first = 0;
      body_left--;
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_byte    = 8'h00;
    in_body    = 1'b0;
    body_start = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, at the first phase's idling rates.
    in_idle_pct  = 12;
    out_idle_pct = 60;
    send_byte(8'hd7, 1'b1, 1'b1);     // stream start: zero window, store expands
    send_byte(wor_pkg::OP_DROP, 1'b1, 1'b0);   // drop right after a store vanishes
    send_byte(wor_pkg::OP_DROP, 1'b1, 1'b0);   // flag now clear, so this one passes
    send_byte(8'he2, 1'b1, 1'b0);     // last store of the table
    send_byte(wor_pkg::OP_DROP, 1'b1, 1'b1);   // new body clears the flag first
    send_byte(8'hd8, 1'b1, 1'b0);
    send_byte(8'h05, 1'b0, 1'b0);     // header byte clears the flag
    send_byte(wor_pkg::OP_DROP, 1'b1, 1'b0);
    send_byte(8'hd0, 1'b1, 1'b0);     // holes in the legacy table
    send_byte(8'hd1, 1'b1, 1'b0);
    send_byte(8'hd2, 1'b1, 1'b0);
    send_byte(8'hc4, 1'b1, 1'b0);     // just outside the table
    send_byte(8'he7, 1'b1, 1'b0);
    send_byte(LEGACY_FIRST, 1'b1, 1'b0); // four high bytes behind: LEB, kept
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(wor_pkg::OP_I32CONST, 1'b1, 1'b0);
    send_byte(8'hcc, 1'b1, 1'b0);     // const without a preceding opcode: LEB
    send_byte(wor_pkg::OP_CALL, 1'b1, 1'b0);
    send_byte(wor_pkg::OP_I64CONST, 1'b1, 1'b0);
    send_byte(8'hcd, 1'b1, 1'b0);     // const after call: real opcode
    send_byte(8'hd3, 1'b1, 1'b0);
    send_byte(LEGACY_LAST, 1'b1, 1'b0);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);     // body_start on a header byte
    send_byte(8'hff, 1'b0, 1'b0);

    // Sender mostly busy, receiver stalls often; one long hold-off.
    in_idle_pct  = 12;
    out_idle_pct = 60;
    hold_request = 1;
    feed_stream(140);

    // Sender sparse, receiver mostly ready.
    in_idle_pct  = 60;
    out_idle_pct = 12;
    feed_stream(140);

    // Full rate both ways, with another hold-off to back the queue up.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_request = 1;
    feed_stream(150);
    in_valid = 1'b0;

    // Drain, then wait for any stray output to show up.
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run: %0d input bytes, %0d output bytes checked", sb.n_in, sb.n_out);
    $display("run: %0d store expansions, %0d drops removed, %0d table bytes kept as LEB",
             sb.n_stores, sb.n_dropped, sb.n_leb_kept);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/wor_pkg.sv
sv/wor_queue.sv
sv/wor_front.sv
sv/wor_back.sv
sv/wasm_opcode_rewriter.sv
sv/wor_checker.sv
tb/tb_wasm_opcode_rewriter.sv
